FILE: rtl/tlvrle_pkg.sv
// ----------------------------------------------------------------------------
// tlvrle_pkg
// Types and constants shared by the run-length palette image decoder.
// ----------------------------------------------------------------------------
package tlvrle_pkg;

    // File layout
    localparam int unsigned HEADER_BYTES = 3;
    localparam int unsigned TYPE_BYTES   = 1;
    localparam int unsigned LENGTH_BYTES = 2;
    localparam int unsigned ENTRY_BYTES  = 7;   // palette entry: 3 skipped, key, r, g, b
    localparam int unsigned PAL_DEPTH    = 256;
    localparam int unsigned RGB_W        = 24;
    localparam int unsigned PIX_W        = 24;

    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    // Section types
    localparam logic [7:0] SEC_NAME    = 8'd2;
    localparam logic [7:0] SEC_PALETTE = 8'd3;
    localparam logic [7:0] SEC_ROWS    = 8'd5;

    // Row and item codes
    localparam logic [7:0] TAG_ROW     = 8'd6;
    localparam logic [7:0] ITEM_RUN    = 8'd7;
    localparam logic [7:0] ITEM_SINGLE = 8'd8;

    // Byte positions inside a palette entry / item
    localparam logic [2:0] POS_KEY       = 3'd3;
    localparam logic [2:0] POS_RED       = 3'd4;
    localparam logic [2:0] POS_GREEN     = 3'd5;
    localparam logic [2:0] POS_BLUE      = 3'd6;
    localparam logic [2:0] POS_ITEM_CODE = 3'd0;
    localparam logic [2:0] POS_SGL_FIRST = 3'd1;
    localparam logic [2:0] POS_SGL_KEY   = 3'd3;
    localparam logic [2:0] POS_RUN_FIRST = 3'd4;
    localparam logic [2:0] POS_RUN_CNT   = 3'd6;
    localparam logic [2:0] POS_RUN_KEY   = 3'd7;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_SECTION  = 2'd1;
    localparam logic [1:0] ERR_ITEM     = 2'd2;
    localparam logic [1:0] ERR_ROW_LEN  = 2'd3;

    typedef enum logic [10:0] {
        PH_HEADER     = 11'b000_0000_0001,
        PH_SEC_TYPE   = 11'b000_0000_0010,
        PH_SEC_LEN_HI = 11'b000_0000_0100,
        PH_SEC_LEN_LO = 11'b000_0000_1000,
        PH_SKIP       = 11'b000_0001_0000,
        PH_PALETTE    = 11'b000_0010_0000,
        PH_ROW_TAG    = 11'b000_0100_0000,
        PH_ROW_LEN_HI = 11'b000_1000_0000,
        PH_ROW_LEN_LO = 11'b001_0000_0000,
        PH_ROW_BODY   = 11'b010_0000_0000,
        PH_DONE       = 11'b100_0000_0000
    } phase_t;

    // One decoded result waiting for its palette colour
    typedef struct packed {
        logic [7:0] key;
        logic [7:0] run;
        logic       row_end;
        logic       hit;
        logic [1:0] err;
    } result_t;

endpackage

FILE: rtl/tlvrle_ram.sv
// ----------------------------------------------------------------------------
// tlvrle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlvrle_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/tlv_rle_palette_image_decoder.sv
// ----------------------------------------------------------------------------
// tlv_rle_palette_image_decoder
// Parses a type-length-value image file byte by byte and gives out one
// transaction per pixel item or run, row end or error, coloured from a 256-entry palette.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Width | Contents
//  --------+-----+-------+----------------------------------------------------
//  s_*     | in  | 8+1   | file bytes; tuser = start of file
//  m_*     | out | 48+1  | key, rgb, run length, hit, error; tlast = row end
//
//  One byte is accepted per cycle unless both stages are full and m_tready is
//  low. A result is held in the parser register while the palette RAM read
//  completes, then in the output register.
//  Reset clears the parser and the palette valid flags at once; there is
//  no clearing pass. A start-of-file byte clears them the same way.
//  A stall on m_tready holds both stages; s_tready drops only when both are
//  full.
//
// ----------------------------------------------------------------------------
module tlv_rle_palette_image_decoder (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] start_of_file

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [7:0] pixel_key, [15:8] red, [23:16] green,
                                    // [31:24] blue, [39:32] run_length,
                                    // [40] palette_hit, [42:41] error_code, rest 0
    output logic        m_tlast     // [0] row_end
);

    localparam int unsigned KEY_W = $clog2(tlvrle_pkg::PAL_DEPTH);

    // ---------------------------------------------------------------- parser state
    tlvrle_pkg::phase_t       phase_reg, phase_next;
    logic [1:0]               sections_reg, sections_next;
    logic [15:0]              sec_left_reg, sec_left_next;
    logic [15:0]              row_left_reg, row_left_next;
    logic [2:0]               bpos_reg, bpos_next;
    logic [7:0]               pend_reg, pend_next;      // section type, key or run count
    logic [7:0]               red_reg, red_next;        // palette colour being collected
    logic [7:0]               green_reg, green_next;
    logic [tlvrle_pkg::PIX_W-1:0] cur_pix_reg, cur_pix_next;
    logic [tlvrle_pkg::PIX_W-1:0] first_pix_reg, first_pix_next;
    logic [tlvrle_pkg::PAL_DEPTH-1:0] valid_reg, valid_next;

    // ---------------------------------------------------------------- pipeline
    tlvrle_pkg::result_t      s1_reg, s1_next;
    logic                     s1_valid_reg;
    logic                     emit;
    logic                     s_fire;
    logic                     s1_move;

    tlvrle_pkg::result_t      out_reg;
    logic [tlvrle_pkg::RGB_W-1:0] out_rgb_reg;
    logic                     out_valid_reg;

    // ---------------------------------------------------------------- palette RAM
    logic                     ram_we;
    logic [KEY_W-1:0]         ram_waddr;
    logic [tlvrle_pkg::RGB_W-1:0] ram_wdata;
    logic                     ram_re;
    logic [tlvrle_pkg::RGB_W-1:0] ram_rdata;

    // Reads happen only in row phases, writes only in palette phases, so a
    // read and a write never meet on the same byte and no forwarding is needed.
    tlvrle_ram #(
        .WIDTH (tlvrle_pkg::RGB_W),
        .DEPTH (tlvrle_pkg::PAL_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (s1_next.key),
        .rdata (ram_rdata)
    );

    assign s1_move  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_move;
    assign s_fire   = s_tvalid && s_tready;

    // ---------------------------------------------------------------- byte parser
    always_comb
    begin
        logic        last;
        logic        closing;
        logic        end_sec;
        logic        has_item;
        logic        mismatch;
        logic [24:0] sum;
        logic [1:0]  sec_dec;

        phase_next     = phase_reg;
        sections_next  = sections_reg;
        sec_left_next  = sec_left_reg;
        row_left_next  = row_left_reg;
        bpos_next      = bpos_reg;
        pend_next      = pend_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        cur_pix_next   = cur_pix_reg;
        first_pix_next = first_pix_reg;
        valid_next     = valid_reg;

        // new file: restart parser, forget palette and reference row length
        if (s_tuser)
        begin
            phase_next     = tlvrle_pkg::PH_HEADER;
            sections_next  = 2'd3;
            sec_left_next  = '0;
            row_left_next  = '0;
            bpos_next      = '0;
            pend_next      = '0;
            cur_pix_next   = '0;
            first_pix_next = '0;
            valid_next     = '0;
        end

        emit      = 1'b0;
        has_item  = 1'b0;
        s1_next   = '0;
        last      = 1'b0;
        closing   = 1'b0;
        end_sec   = 1'b0;
        mismatch  = 1'b0;
        sum       = '0;
        sec_dec   = '0;
        ram_we    = 1'b0;
        ram_waddr = pend_next;
        ram_wdata = {red_next, green_next, s_tdata};

        unique case (phase_next)
            tlvrle_pkg::PH_HEADER:
            begin
                if (bpos_next >= 3'(tlvrle_pkg::HEADER_BYTES - 1))
                begin
                    phase_next = tlvrle_pkg::PH_SEC_TYPE;
                    bpos_next  = '0;
                end
                else
                begin
                    bpos_next = bpos_next + 3'd1;
                end
            end

            tlvrle_pkg::PH_SEC_TYPE:
            begin
                pend_next = s_tdata;
                if (s_tdata != tlvrle_pkg::SEC_NAME && s_tdata != tlvrle_pkg::SEC_PALETTE
                    && s_tdata != tlvrle_pkg::SEC_ROWS)
                begin
                    emit        = 1'b1;
                    s1_next.err = tlvrle_pkg::ERR_SECTION;
                end
                phase_next = tlvrle_pkg::PH_SEC_LEN_HI;
            end

            tlvrle_pkg::PH_SEC_LEN_HI:
            begin
                sec_left_next = {s_tdata, 8'h00};
                phase_next    = tlvrle_pkg::PH_SEC_LEN_LO;
            end

            tlvrle_pkg::PH_SEC_LEN_LO:
            begin
                sec_left_next = {sec_left_next[15:8], s_tdata};
                bpos_next     = '0;
                if (sec_left_next == '0)
                begin
                    end_sec = 1'b1;
                end
                else if (pend_next == tlvrle_pkg::SEC_PALETTE)
                begin
                    phase_next = tlvrle_pkg::PH_PALETTE;
                end
                else if (pend_next == tlvrle_pkg::SEC_ROWS)
                begin
                    phase_next = tlvrle_pkg::PH_ROW_TAG;
                end
                else
                begin
                    phase_next = tlvrle_pkg::PH_SKIP;
                end
            end

            tlvrle_pkg::PH_SKIP,
            tlvrle_pkg::PH_PALETTE:
            begin
                last = (sec_left_next <= 16'd1);
                // too few bytes left for a whole entry: skip the tail
                if (phase_next == tlvrle_pkg::PH_PALETTE && bpos_next == '0
                    && sec_left_next < 16'(tlvrle_pkg::ENTRY_BYTES))
                begin
                    phase_next = tlvrle_pkg::PH_SKIP;
                end
                if (phase_next == tlvrle_pkg::PH_PALETTE)
                begin
                    priority if (bpos_next < tlvrle_pkg::POS_KEY)
                    begin
                        bpos_next = bpos_next + 3'd1;
                    end
                    else if (bpos_next == tlvrle_pkg::POS_KEY)
                    begin
                        pend_next = s_tdata;
                        bpos_next = bpos_next + 3'd1;
                    end
                    else if (bpos_next == tlvrle_pkg::POS_RED)
                    begin
                        red_next  = s_tdata;
                        bpos_next = bpos_next + 3'd1;
                    end
                    else if (bpos_next == tlvrle_pkg::POS_GREEN)
                    begin
                        green_next = s_tdata;
                        bpos_next  = bpos_next + 3'd1;
                    end
                    else
                    begin
                        // blue: whole colour goes in at once; first definition wins
                        ram_we               = s_fire && !valid_next[pend_next];
                        valid_next[pend_next] = 1'b1;
                        bpos_next            = '0;
                    end
                end
                if (sec_left_next != '0)
                begin
                    sec_left_next = sec_left_next - 16'd1;
                end
                end_sec = last;
            end

            tlvrle_pkg::PH_ROW_TAG,
            tlvrle_pkg::PH_ROW_LEN_HI,
            tlvrle_pkg::PH_ROW_LEN_LO,
            tlvrle_pkg::PH_ROW_BODY:
            begin
                last = (sec_left_next <= 16'd1);
                if (sec_left_next != '0)
                begin
                    sec_left_next = sec_left_next - 16'd1;
                end
                unique case (phase_next)
                    tlvrle_pkg::PH_ROW_TAG:
                    begin
                        if (s_tdata == tlvrle_pkg::TAG_ROW)
                        begin
                            cur_pix_next = '0;
                            phase_next   = tlvrle_pkg::PH_ROW_LEN_HI;
                            closing      = last;
                        end
                        else
                        begin
                            phase_next = tlvrle_pkg::PH_SKIP;
                        end
                    end
                    tlvrle_pkg::PH_ROW_LEN_HI:
                    begin
                        row_left_next = {s_tdata, 8'h00};
                        phase_next    = tlvrle_pkg::PH_ROW_LEN_LO;
                        closing       = last;
                    end
                    tlvrle_pkg::PH_ROW_LEN_LO:
                    begin
                        row_left_next = {row_left_next[15:8], s_tdata};
                        bpos_next     = '0;
                        phase_next    = tlvrle_pkg::PH_ROW_BODY;
                        closing       = last || (row_left_next == '0);
                    end
                    default:
                    begin
                        unique case (bpos_next)
                            tlvrle_pkg::POS_ITEM_CODE:
                            begin
                                if (s_tdata == tlvrle_pkg::ITEM_SINGLE)
                                begin
                                    bpos_next = tlvrle_pkg::POS_SGL_FIRST;
                                end
                                else if (s_tdata == tlvrle_pkg::ITEM_RUN)
                                begin
                                    bpos_next = tlvrle_pkg::POS_RUN_FIRST;
                                end
                                else
                                begin
                                    emit        = 1'b1;
                                    s1_next.err = tlvrle_pkg::ERR_ITEM;
                                end
                            end
                            tlvrle_pkg::POS_SGL_KEY:
                            begin
                                has_item    = 1'b1;
                                s1_next.key = s_tdata;
                                s1_next.run = 8'd1;
                                bpos_next   = '0;
                            end
                            tlvrle_pkg::POS_RUN_CNT:
                            begin
                                pend_next = s_tdata;
                                bpos_next = tlvrle_pkg::POS_RUN_KEY;
                            end
                            tlvrle_pkg::POS_RUN_KEY:
                            begin
                                has_item    = 1'b1;
                                s1_next.key = s_tdata;
                                s1_next.run = pend_next;
                                bpos_next   = '0;
                            end
                            default:
                            begin
                                bpos_next = bpos_next + 3'd1;
                            end
                        endcase
                        if (has_item)
                        begin
                            emit = 1'b1;
                            sum  = {1'b0, cur_pix_next} + {17'd0, s1_next.run};
                            cur_pix_next = sum[24] ? tlvrle_pkg::PIX_MAX : sum[23:0];
                        end
                        if (row_left_next != '0)
                        begin
                            row_left_next = row_left_next - 16'd1;
                        end
                        closing = last || (row_left_next == '0);
                    end
                endcase
                end_sec = last;
            end

            default:
            begin
                // after the third section: ignore bytes
            end
        endcase

        // row close: first non-empty row sets the reference pixel count
        if (closing)
        begin
            if (first_pix_next == '0)
            begin
                first_pix_next = cur_pix_next;
            end
            else
            begin
                mismatch = (cur_pix_next != first_pix_next);
            end
            emit            = 1'b1;
            s1_next.row_end = 1'b1;
            if (mismatch)
            begin
                s1_next.err = tlvrle_pkg::ERR_ROW_LEN;
            end
            phase_next = tlvrle_pkg::PH_ROW_TAG;
        end

        if (end_sec)
        begin
            sec_dec       = (sections_next != '0) ? 2'd1 : 2'd0;
            sections_next = sections_next - sec_dec;
            phase_next    = (sections_next == '0) ? tlvrle_pkg::PH_DONE
                                                  : tlvrle_pkg::PH_SEC_TYPE;
        end

        s1_next.hit = has_item && valid_next[s1_next.key];
        ram_re      = s_fire && has_item;
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= tlvrle_pkg::PH_HEADER;
            sections_reg  <= 2'd3;
            sec_left_reg  <= '0;
            row_left_reg  <= '0;
            bpos_reg      <= '0;
            pend_reg      <= '0;
            cur_pix_reg   <= '0;
            first_pix_reg <= '0;
            valid_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                phase_reg     <= phase_next;
                sections_reg  <= sections_next;
                sec_left_reg  <= sec_left_next;
                row_left_reg  <= row_left_next;
                bpos_reg      <= bpos_next;
                pend_reg      <= pend_next;
                cur_pix_reg   <= cur_pix_next;
                first_pix_reg <= first_pix_next;
                valid_reg     <= valid_next;
                s1_valid_reg  <= emit;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            s1_reg    <= s1_next;
        end
        if (s1_move)
        begin
            out_reg     <= s1_reg;
            out_rgb_reg <= s1_reg.hit ? ram_rdata : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.row_end;
    assign m_tdata  = {5'd0, out_reg.err, out_reg.hit, out_reg.run,
                       out_rgb_reg[7:0], out_rgb_reg[15:8], out_rgb_reg[23:16],
                       out_reg.key};

    // ---------------------------------------------------------------- assertions
    // palette writes and colour reads belong to different sections
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && s_fire && ram_re))
        else $error("palette write and read on the same byte");

    // a held result stays held while the output is stalled
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !m_tready |=> s1_valid_reg)
        else $error("parser result lost under stall");

    // both stages full and stalled: no byte may enter
    a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("byte accepted with pipeline full");

    // an unknown section result carries no item
    a_sec_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[42:41] == tlvrle_pkg::ERR_SECTION
        |-> m_tdata[39:32] == 8'd0 && !m_tdata[40] && !m_tlast)
        else $error("section error result carries an item");

endmodule
